[design/stat_pkg.sv]
// Package for the sensor threshold alert table.
// Holds request, severity and event codes, register indexes, reset limits
// and the marker byte lookup. Depends on nothing.
package stat_pkg;

  localparam int TEMP_W    = 18;
  localparam int PCT_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 18;

  typedef enum logic [1:0] {
    REQ_TEMP     = 2'd0,
    REQ_HUMIDITY = 2'd1,
    REQ_SOIL     = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    SEV_NONE     = 3'd0,
    SEV_LOW      = 3'd1,
    SEV_MEDIUM   = 3'd2,
    SEV_HIGH     = 3'd3,
    SEV_CRITICAL = 3'd4
  } sev_t;

  typedef enum logic [2:0] {
    EVT_NONE      = 3'd0,
    EVT_TEMP_HIGH = 3'd1,
    EVT_TEMP_LOW  = 3'd2,
    EVT_HUM_HIGH  = 3'd3,
    EVT_HUM_LOW   = 3'd4,
    EVT_SOIL_DRY  = 3'd5
  } evt_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SOIL_DRY  = 3'd4;

  // Limit values after reset
  localparam logic signed [TEMP_W-1:0] RST_TEMP_HIGH = 18'sd40000;
  localparam logic signed [TEMP_W-1:0] RST_TEMP_LOW  = -18'sd10000;
  localparam logic [PCT_W-1:0]         RST_HUM_HIGH  = 8'd90;
  localparam logic [PCT_W-1:0]         RST_HUM_LOW   = 8'd10;
  localparam logic [PCT_W-1:0]         RST_SOIL_DRY  = 8'd20;

  // Notification markers
  localparam logic [7:0] MARK_CRITICAL = 8'h21; // '!'
  localparam logic [7:0] MARK_HIGH     = 8'h5E; // '^'
  localparam logic [7:0] MARK_MEDIUM   = 8'h7E; // '~'
  localparam logic [7:0] MARK_LOW      = 8'h2E; // '.'

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_high;
    logic signed [TEMP_W-1:0] temp_low;
    logic [PCT_W-1:0]         hum_high;
    logic [PCT_W-1:0]         hum_low;
    logic [PCT_W-1:0]         soil_dry;
  } limits_t;

  typedef struct packed {
    logic valid;  // an item is present this cycle
    logic raise;  // a limit was crossed
    logic clear;  // clear-all request
    sev_t sev;
    evt_t evt;
  } alert_t;

  function automatic logic [7:0] marker_for(sev_t sev);
    logic [7:0] m;
    case (sev)
      SEV_CRITICAL: m = MARK_CRITICAL;
      SEV_HIGH:     m = MARK_HIGH;
      SEV_MEDIUM:   m = MARK_MEDIUM;
      default:      m = MARK_LOW;
    endcase
    return m;
  endfunction

endpackage

[design/sensor_threshold_alert_table.sv]
// Top level of the sensor threshold alert table.
// Depends on stat_pkg, stat_limit_regs, stat_classify and stat_alert_table.
//
//   Request channel: a request (req_type, temp_reading, percent_reading) is
//   taken at a rising edge where start is high and busy is low. busy is
//   high while reset is held and for the first cycle after it drops; after
//   that one request can be issued every cycle.
//   Result channel: done pulses for one cycle with the result on the result
//   ports. A taken request goes through the input register and then the
//   result register before its result shows. Throughput is one request per
//   cycle, set by the single registered pass from the input register
//   through the limit compare to the result register. The receiver cannot
//   stall; take every result while done is high.
//   Configuration channel: cfg_ready follows !busy; a write lands when
//   cfg_valid and cfg_ready are both high. Indexes beyond the five limits
//   are ignored. Write limits only while no request is in flight.
//   Reset (rst, synchronous) restores the default limits and empties the
//   alert table. Slots fill lowest first and clear only all together, so
//   the table is held as a fill count and a running maximum severity.
module sensor_threshold_alert_table
  import stat_pkg::*;
#(
  parameter int ALERT_SLOTS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           req_type,
  input  logic signed [17:0]   temp_reading,
  input  logic [7:0]           percent_reading,
  output logic                 done,
  output logic                 alert_stored,
  output logic                 alert_dropped,
  output logic [2:0]           raised_severity,
  output logic [2:0]           raised_event,
  output logic [7:0]           notify_byte,
  output logic [3:0]           active_count,
  output logic [2:0]           highest_severity,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  logic                     req_valid;
  req_t                     req_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic [PCT_W-1:0]         pct_q;
  limits_t                  limits;
  alert_t                   alert;
  logic                     accept;

  // Limits are plain registers: ready as soon as busy drops after reset
  assign cfg_ready = !busy;
  assign accept    = start && !busy;

  // Hold busy for one cycle out of reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      req_valid <= 1'b0;
    end else begin
      busy      <= 1'b0;
      req_valid <= accept;
    end
  end

  // Input register: capture the request fields
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= req_t'(req_type);
      temp_q <= temp_reading;
      pct_q  <= percent_reading;
    end
  end

  stat_limit_regs u_limits (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .limits   (limits)
  );

  stat_classify u_classify (
    .valid  (req_valid),
    .req    (req_q),
    .temp   (temp_q),
    .pct    (pct_q),
    .limits (limits),
    .alert  (alert)
  );

  stat_alert_table #(
    .ALERT_SLOTS (ALERT_SLOTS)
  ) u_table (
    .clk              (clk),
    .rst              (rst),
    .alert            (alert),
    .done             (done),
    .alert_stored     (alert_stored),
    .alert_dropped    (alert_dropped),
    .raised_severity  (raised_severity),
    .raised_event     (raised_event),
    .notify_byte      (notify_byte),
    .active_count     (active_count),
    .highest_severity (highest_severity)
  );

endmodule

[design/stat_limit_regs.sv]
// Configuration registers holding the five alert limits.
// Depends on stat_pkg for indexes, widths and reset values.
module stat_limit_regs
  import stat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_DAT_W-1:0] wr_data,
  output limits_t              limits
);

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.temp_high <= RST_TEMP_HIGH;
      limits.temp_low  <= RST_TEMP_LOW;
      limits.hum_high  <= RST_HUM_HIGH;
      limits.hum_low   <= RST_HUM_LOW;
      limits.soil_dry  <= RST_SOIL_DRY;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_TEMP_HIGH: limits.temp_high <= $signed(wr_data[TEMP_W-1:0]);
        CFG_TEMP_LOW:  limits.temp_low  <= $signed(wr_data[TEMP_W-1:0]);
        CFG_HUM_HIGH:  limits.hum_high  <= wr_data[PCT_W-1:0];
        CFG_HUM_LOW:   limits.hum_low   <= wr_data[PCT_W-1:0];
        CFG_SOIL_DRY:  limits.soil_dry  <= wr_data[PCT_W-1:0];
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

endmodule

[design/stat_classify.sv]
// Limit comparison: turns one registered request into an alert code.
// Depends on stat_pkg for request, severity and event codes.
module stat_classify
  import stat_pkg::*;
(
  input  logic                     valid,
  input  req_t                     req,
  input  logic signed [TEMP_W-1:0] temp,
  input  logic [PCT_W-1:0]         pct,
  input  limits_t                  limits,
  output alert_t                   alert
);

  always_comb begin
    alert.valid = valid;
    alert.raise = 1'b0;
    alert.clear = 1'b0;
    alert.sev   = SEV_NONE;
    alert.evt   = EVT_NONE;
    unique case (req)
      REQ_TEMP: begin
        if (temp > limits.temp_high) begin
          alert.raise = 1'b1;
          alert.sev   = SEV_HIGH;
          alert.evt   = EVT_TEMP_HIGH;
        end else if (temp < limits.temp_low) begin
          alert.raise = 1'b1;
          alert.sev   = SEV_MEDIUM;
          alert.evt   = EVT_TEMP_LOW;
        end
      end
      REQ_HUMIDITY: begin
        // high test first: it wins when limits overlap
        if (pct > limits.hum_high) begin
          alert.raise = 1'b1;
          alert.sev   = SEV_LOW;
          alert.evt   = EVT_HUM_HIGH;
        end else if (pct < limits.hum_low) begin
          alert.raise = 1'b1;
          alert.sev   = SEV_MEDIUM;
          alert.evt   = EVT_HUM_LOW;
        end
      end
      REQ_SOIL: begin
        if (pct < limits.soil_dry) begin
          alert.raise = 1'b1;
          alert.sev   = SEV_HIGH;
          alert.evt   = EVT_SOIL_DRY;
        end
      end
      REQ_CLEAR: alert.clear = 1'b1;
      default: ;
    endcase
  end

endmodule

[design/stat_alert_table.sv]
// Alert table occupancy and result register.
// Depends on stat_pkg for the alert struct, codes and marker lookup.
module stat_alert_table
  import stat_pkg::*;
#(
  parameter int ALERT_SLOTS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  alert_t     alert,
  output logic       done,
  output logic       alert_stored,
  output logic       alert_dropped,
  output logic [2:0] raised_severity,
  output logic [2:0] raised_event,
  output logic [7:0] notify_byte,
  output logic [3:0] active_count,
  output logic [2:0] highest_severity
);

  localparam int CNT_W = $clog2(ALERT_SLOTS + 1);

  // Slots fill lowest first and are only freed all at once, so the
  // occupied slots are always a prefix: the fill count is the table.
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  sev_t             top_sev;
  sev_t             top_sev_next;
  logic             full;
  logic             store;

  assign full  = (fill == CNT_W'(ALERT_SLOTS));
  assign store = alert.valid && alert.raise && !full;

  always_comb begin
    fill_next    = fill;
    top_sev_next = top_sev;
    if (alert.valid && alert.clear) begin
      fill_next    = '0;
      top_sev_next = SEV_NONE;
    end else if (store) begin
      fill_next = fill + CNT_W'(1);
      if (alert.sev > top_sev) begin
        top_sev_next = alert.sev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      top_sev <= SEV_NONE;
      done    <= 1'b0;
    end else begin
      fill    <= fill_next;
      top_sev <= top_sev_next;
      done    <= alert.valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (alert.valid) begin
      alert_stored     <= store;
      alert_dropped    <= alert.raise && full;
      raised_severity  <= store ? alert.sev : SEV_NONE;
      raised_event     <= store ? alert.evt : EVT_NONE;
      notify_byte      <= store ? marker_for(alert.sev) : 8'h00;
      active_count     <= 4'(fill_next);
      highest_severity <= top_sev_next;
    end
  end

endmodule

[tb/alert_tb_pkg.sv]
// Scoreboard for the sensor threshold alert table testbench.
// Predicts each result from the limits and a shadow alert table; depends on stat_pkg.
package alert_tb_pkg;
  import stat_pkg::*;

  typedef struct {
    logic       stored;
    logic       dropped;
    logic [2:0] sev;
    logic [2:0] evt;
    logic [7:0] marker;
    logic [3:0] count;
    logic [2:0] top_sev;
  } alert_outcome_t;

  localparam int TABLE_SLOTS = 8;
  localparam int MAX_PRINTED = 40;

  class alert_scoreboard;
    logic signed [TEMP_W-1:0] temp_hi;
    logic signed [TEMP_W-1:0] temp_lo;
    logic [PCT_W-1:0]         hum_hi;
    logic [PCT_W-1:0]         hum_lo;
    logic [PCT_W-1:0]         soil_lim;
    bit                       slot_on [TABLE_SLOTS];
    sev_t                     slot_sev [TABLE_SLOTS];
    int unsigned              fill;
    alert_outcome_t           outcome_q [$];
    int unsigned              errors;
    int unsigned              matched;
    int unsigned              n_requests;
    int unsigned              n_stored;
    int unsigned              n_dropped;
    int unsigned              n_clears;

    function new();
      temp_hi  = RST_TEMP_HIGH;
      temp_lo  = RST_TEMP_LOW;
      hum_hi   = RST_HUM_HIGH;
      hum_lo   = RST_HUM_LOW;
      soil_lim = RST_SOIL_DRY;
      foreach (slot_on[i]) begin
        slot_on[i]  = 1'b0;
        slot_sev[i] = SEV_NONE;
      end
      fill       = 0;
      errors     = 0;
      matched    = 0;
      n_requests = 0;
      n_stored   = 0;
      n_dropped  = 0;
      n_clears   = 0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_TEMP_HIGH: temp_hi  = data;
        CFG_TEMP_LOW:  temp_lo  = data;
        CFG_HUM_HIGH:  hum_hi   = data[PCT_W-1:0];
        CFG_HUM_LOW:   hum_lo   = data[PCT_W-1:0];
        CFG_SOIL_DRY:  soil_lim = data[PCT_W-1:0];
        default: ;
      endcase
    endfunction

    // Classify one reading, update the shadow table and queue the result.
    function void take_request(req_t kind, logic signed [TEMP_W-1:0] temp,
                               logic [PCT_W-1:0] pct);
      sev_t           sev;
      evt_t           evt;
      alert_outcome_t o;
      int             free_slot;
      int             i;
      sev       = SEV_NONE;
      evt       = EVT_NONE;
      free_slot = -1;
      o         = '{default: '0};
      n_requests++;
      case (kind)
        REQ_TEMP: begin
          if (temp > temp_hi) begin
            sev = SEV_HIGH;
            evt = EVT_TEMP_HIGH;
          end else if (temp < temp_lo) begin
            sev = SEV_MEDIUM;
            evt = EVT_TEMP_LOW;
          end
        end
        REQ_HUMIDITY: begin
          if (pct > hum_hi) begin
            sev = SEV_LOW;
            evt = EVT_HUM_HIGH;
          end else if (pct < hum_lo) begin
            sev = SEV_MEDIUM;
            evt = EVT_HUM_LOW;
          end
        end
        REQ_SOIL: begin
          if (pct < soil_lim) begin
            sev = SEV_HIGH;
            evt = EVT_SOIL_DRY;
          end
        end
        default: begin
          foreach (slot_on[j]) slot_on[j] = 1'b0;
          fill = 0;
          n_clears++;
        end
      endcase
      if (sev != SEV_NONE) begin
        for (i = 0; i < TABLE_SLOTS && free_slot < 0; i++)
          if (!slot_on[i]) free_slot = i;
        if (free_slot < 0) begin
          o.dropped = 1'b1;
          n_dropped++;
        end else begin
          slot_on[free_slot]  = 1'b1;
          slot_sev[free_slot] = sev;
          fill++;
          o.stored = 1'b1;
          o.sev    = sev;
          o.evt    = evt;
          case (sev)
            SEV_CRITICAL: o.marker = MARK_CRITICAL;
            SEV_HIGH:     o.marker = MARK_HIGH;
            SEV_MEDIUM:   o.marker = MARK_MEDIUM;
            default:      o.marker = MARK_LOW;
          endcase
          n_stored++;
        end
      end
      o.count   = 4'(fill);
      o.top_sev = SEV_NONE;
      for (i = 0; i < TABLE_SLOTS; i++)
        if (slot_on[i] && slot_sev[i] > o.top_sev) o.top_sev = slot_sev[i];
      outcome_q.push_back(o);
    endfunction

    function int unsigned pending();
      return outcome_q.size();
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED) $display("MISMATCH %s", msg);
      errors++;
    endtask

    task check_field(string name, logic [7:0] want, logic [7:0] seen);
      if (seen !== want)
        report($sformatf("%s: expected %0d, got %0d (result %0d)", name, want, seen, matched));
    endtask

    task match_outcome(alert_outcome_t got);
      alert_outcome_t want;
      if (outcome_q.size() == 0) begin
        report($sformatf("result with no request pending (after %0d results)", matched));
      end else begin
        want = outcome_q.pop_front();
        check_field("alert_stored", 8'(want.stored), 8'(got.stored));
        check_field("alert_dropped", 8'(want.dropped), 8'(got.dropped));
        check_field("raised_severity", 8'(want.sev), 8'(got.sev));
        check_field("raised_event", 8'(want.evt), 8'(got.evt));
        check_field("notify_byte", want.marker, got.marker);
        check_field("active_count", 8'(want.count), 8'(got.count));
        check_field("highest_severity", 8'(want.top_sev), 8'(got.top_sev));
        matched++;
      end
    endtask
  endclass

endpackage

[tb/tb_top.sv]
// Testbench top for the sensor threshold alert table.
// Drives requests and limit writes with plain tasks, checks every result
// against alert_tb_pkg's scoreboard; depends on stat_pkg and alert_tb_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import stat_pkg::*;
  import alert_tb_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int PHASES          = 8;
  localparam int DRAIN_LIMIT     = 64;
  localparam int DRAIN_CYCLES    = 6;
  localparam int TEMP_MAX        = 131071;
  localparam int TEMP_MIN        = -131072;

  logic                 clk             = 1'b0;
  logic                 rst             = 1'b1;
  logic                 start           = 1'b0;
  logic [1:0]           req_type        = REQ_TEMP;
  logic signed [17:0]   temp_reading    = '0;
  logic [7:0]           percent_reading = '0;
  logic                 cfg_valid       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = CFG_TEMP_HIGH;
  logic [CFG_DAT_W-1:0] cfg_data        = '0;

  logic       busy;
  logic       done;
  logic       alert_stored;
  logic       alert_dropped;
  logic [2:0] raised_severity;
  logic [2:0] raised_event;
  logic [7:0] notify_byte;
  logic [3:0] active_count;
  logic [2:0] highest_severity;
  logic       cfg_ready;

  alert_scoreboard sb;
  int unsigned     cycle_count = 0;
  bit              no_idle     = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sensor_threshold_alert_table #(
    .ALERT_SLOTS(TABLE_SLOTS)
  ) u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .req_type        (req_type),
    .temp_reading    (temp_reading),
    .percent_reading (percent_reading),
    .done            (done),
    .alert_stored    (alert_stored),
    .alert_dropped   (alert_dropped),
    .raised_severity (raised_severity),
    .raised_event    (raised_event),
    .notify_byte     (notify_byte),
    .active_count    (active_count),
    .highest_severity(highest_severity),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Watchdog: abort a hung run well past the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Take each result in the cycle done is high; the receiver never stalls,
  // so sample the pre-edge values at every rising edge.
  always @(posedge clk) begin : take_results
    alert_outcome_t got;
    if (!rst && done === 1'b1) begin
      got.stored  = alert_stored;
      got.dropped = alert_dropped;
      got.sev     = raised_severity;
      got.evt     = raised_event;
      got.marker  = notify_byte;
      got.count   = active_count;
      got.top_sev = highest_severity;
      sb.match_outcome(got);
    end
  end

  // Mostly back-to-back, sometimes a short gap, rarely a long pause.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Aim at either temperature limit, the full range or the extremes.
  function automatic logic signed [17:0] pick_temp();
    int v;
    case ($urandom_range(0, 5))
      0, 1:    v = int'(sb.temp_hi) + int'($urandom_range(0, 6)) - 3;
      2, 3:    v = int'(sb.temp_lo) + int'($urandom_range(0, 6)) - 3;
      4:       v = int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
      default: v = $urandom_range(0, 1) ? TEMP_MAX : TEMP_MIN;
    endcase
    if (v > TEMP_MAX) v = TEMP_MAX;
    if (v < TEMP_MIN) v = TEMP_MIN;
    return v[17:0];
  endfunction

  // Aim at the limit that the request type uses; random for the others.
  function automatic logic [7:0] pick_pct(req_t kind);
    int base;
    int v;
    case (kind)
      REQ_HUMIDITY: base = $urandom_range(0, 1) ? int'(sb.hum_hi) : int'(sb.hum_lo);
      REQ_SOIL:     base = int'(sb.soil_lim);
      default:      base = $urandom_range(0, 255);
    endcase
    case ($urandom_range(0, 4))
      0, 1:    v = base + int'($urandom_range(0, 4)) - 2;
      2:       v = $urandom_range(0, 255);
      3:       v = $urandom_range(0, 1) ? 255 : 0;
      default: v = base;
    endcase
    if (v > 255) v = 255;
    if (v < 0) v = 0;
    return v[7:0];
  endfunction

  // Present one request, hold it until accepted, then idle for a random gap.
  // Leave start high when the next request follows back to back.
  task automatic send_request(req_t kind, logic signed [17:0] temp, logic [7:0] pct);
    int gap;
    start           <= 1'b1;
    req_type        <= kind;
    temp_reading    <= temp;
    percent_reading <= pct;
    do @(posedge clk); while (busy !== 1'b0);
    sb.take_request(kind, temp, pct);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and hold off until every pending result has come back.
  // Flag and flush whatever is still owed after a bounded wait.
  task automatic wait_drained();
    int n;
    start <= 1'b0;
    n = 0;
    while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending()));
      sb.outcome_q.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all five limits back to back, then stray writes to unused indexes
  // that must leave the limits alone. Call only while the block is idle.
  task automatic program_limits(logic [CFG_DAT_W-1:0] lim [5], int stray);
    int                   k;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
    for (k = 0; k < 5 + stray; k++) begin
      if (k < 5) begin
        idx  = CFG_IDX_W'(k);
        data = lim[k];
      end else begin
        idx  = CFG_IDX_W'($urandom_range(CFG_SOIL_DRY + 1, (1 << CFG_IDX_W) - 1));
        data = CFG_DAT_W'($urandom_range(0, (1 << CFG_DAT_W) - 1));
      end
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= data;
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.set_limit(idx, data);
    end
    cfg_valid <= 1'b0;
  endtask

  // Walk each limit edge under the reset limits, fill the table, overflow it
  // and clear it. Unused reading fields carry random junk.
  task automatic run_directed();
    send_request(REQ_TEMP, 18'(TEMP_MAX), 8'($urandom));
    send_request(REQ_TEMP, 18'sd40000, 8'($urandom));
    send_request(REQ_TEMP, 18'sd40001, 8'($urandom));
    send_request(REQ_TEMP, -18'sd10000, 8'($urandom));
    send_request(REQ_TEMP, -18'sd10001, 8'($urandom));
    send_request(REQ_TEMP, 18'(TEMP_MIN), 8'($urandom));
    send_request(REQ_HUMIDITY, 18'($urandom), 8'd255);
    send_request(REQ_HUMIDITY, 18'($urandom), 8'd90);
    send_request(REQ_HUMIDITY, 18'($urandom), 8'd91);
    send_request(REQ_HUMIDITY, 18'($urandom), 8'd10);
    send_request(REQ_HUMIDITY, 18'($urandom), 8'd9);
    send_request(REQ_SOIL, 18'($urandom), 8'd20);
    // this one takes the last free slot
    send_request(REQ_SOIL, 18'($urandom), 8'd19);
    // table full: both of these must be dropped
    send_request(REQ_SOIL, 18'($urandom), 8'd0);
    send_request(REQ_HUMIDITY, 18'($urandom), 8'd0);
    send_request(REQ_CLEAR, 18'($urandom), 8'($urandom));
    // let everything settle once before refilling
    wait_drained();
    send_request(REQ_SOIL, 18'($urandom), 8'd255);
    send_request(REQ_HUMIDITY, 18'($urandom), 8'd0);
    send_request(REQ_TEMP, 18'sd0, 8'($urandom));
    send_request(REQ_CLEAR, 18'($urandom), 8'($urandom));
    send_request(REQ_CLEAR, 18'($urandom), 8'($urandom));
  endtask

  // Random mix of readings near the limits plus clears; turn idling off for
  // some stretches and occasionally pause until the pipeline is empty.
  task automatic run_random(int n, int clear_pct);
    int   k;
    req_t kind;
    for (k = 0; k < n; k++) begin
      if (k % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 149) == 0) wait_drained();
      if ($urandom_range(0, 99) < clear_pct) kind = REQ_CLEAR;
      else kind = req_t'($urandom_range(REQ_TEMP, REQ_SOIL));
      send_request(kind, pick_temp(), pick_pct(kind));
    end
    no_idle = 1'b0;
  endtask

  initial begin : stimulus
    logic [CFG_DAT_W-1:0] lim [5];
    int                   phase;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Rewrite the reset values plus stray-index writes: the reset limits must stand for the directed part.
    lim[CFG_TEMP_HIGH] = RST_TEMP_HIGH;
    lim[CFG_TEMP_LOW]  = RST_TEMP_LOW;
    lim[CFG_HUM_HIGH]  = CFG_DAT_W'(RST_HUM_HIGH);
    lim[CFG_HUM_LOW]   = CFG_DAT_W'(RST_HUM_LOW);
    lim[CFG_SOIL_DRY]  = CFG_DAT_W'(RST_SOIL_DRY);
    program_limits(lim, 3);
    run_directed();
    wait_drained();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          // nothing can cross: widest possible limits
          lim[CFG_TEMP_HIGH] = CFG_DAT_W'(TEMP_MAX);
          lim[CFG_TEMP_LOW]  = CFG_DAT_W'(TEMP_MIN);
          lim[CFG_HUM_HIGH]  = CFG_DAT_W'(255);
          lim[CFG_HUM_LOW]   = '0;
          lim[CFG_SOIL_DRY]  = '0;
        end
        1: begin
          // nearly everything crosses; humidity limits overlap
          lim[CFG_TEMP_HIGH] = CFG_DAT_W'(TEMP_MIN);
          lim[CFG_TEMP_LOW]  = CFG_DAT_W'(TEMP_MAX);
          lim[CFG_HUM_HIGH]  = '0;
          lim[CFG_HUM_LOW]   = CFG_DAT_W'(255);
          lim[CFG_SOIL_DRY]  = CFG_DAT_W'(255);
        end
        2: begin
          lim[CFG_TEMP_HIGH] = RST_TEMP_HIGH;
          lim[CFG_TEMP_LOW]  = RST_TEMP_LOW;
          lim[CFG_HUM_HIGH]  = CFG_DAT_W'(RST_HUM_HIGH);
          lim[CFG_HUM_LOW]   = CFG_DAT_W'(RST_HUM_LOW);
          lim[CFG_SOIL_DRY]  = CFG_DAT_W'(RST_SOIL_DRY);
        end
        PHASES - 1: begin
          lim[CFG_TEMP_HIGH] = '0;
          lim[CFG_TEMP_LOW]  = '0;
          lim[CFG_HUM_HIGH]  = CFG_DAT_W'(128);
          lim[CFG_HUM_LOW]   = CFG_DAT_W'(128);
          lim[CFG_SOIL_DRY]  = CFG_DAT_W'(128);
        end
        default: begin
          lim[CFG_TEMP_HIGH] = CFG_DAT_W'($urandom_range(0, (1 << CFG_DAT_W) - 1));
          lim[CFG_TEMP_LOW]  = CFG_DAT_W'($urandom_range(0, (1 << CFG_DAT_W) - 1));
          lim[CFG_HUM_HIGH]  = CFG_DAT_W'($urandom_range(0, 255));
          lim[CFG_HUM_LOW]   = CFG_DAT_W'($urandom_range(0, 255));
          lim[CFG_SOIL_DRY]  = CFG_DAT_W'($urandom_range(0, 255));
        end
      endcase
      program_limits(lim, $urandom_range(0, 1));
      run_random(ITEMS_PER_PHASE, $urandom_range(3, 15));
      wait_drained();
    end

    $display("Ran %0d requests over %0d limit settings: %0d alerts stored, %0d dropped, %0d clears.",
             sb.n_requests, PHASES + 1, sb.n_stored, sb.n_dropped, sb.n_clears);
    $display("Checked %0d results, %0d mismatches.", sb.matched, sb.errors);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

[files.f]
design/stat_pkg.sv
design/stat_limit_regs.sv
design/stat_classify.sv
design/stat_alert_table.sv
design/sensor_threshold_alert_table.sv
tb/alert_tb_pkg.sv
tb/tb_top.sv
